// ----- hw/rtl/ptc_pkg.sv -----
`default_nettype none

package ptc_pkg;

    // Sideband that rides along the Heron square-root pipe.
    typedef struct packed {
        logic valid;    // stage holds a live request
        logic tri_ok;   // strict triangle inequality holds
        logic pre;      // H positive and divisible by 16
    } t_area_tag;

    localparam int AREA_TAG_W = $bits(t_area_tag);

endpackage

`default_nettype wire

// ----- hw/rtl/ptc_isqrt.sv -----
`default_nettype none

// Pipelined perfect-square test, one root bit per stage.
module ptc_isqrt #(
    parameter int RB = 31,
    parameter int TW = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic [2*RB-1:0]   i_val,
    input  wire logic [TW-1:0]     i_tag,
    output logic      [TW-1:0]     o_tag,
    output logic                   o_square
);

    logic [RB+1:0]   r_rem  [RB];
    logic [TW-1:0]   r_tag  [RB];
    logic [RB-1:0]   r_root [RB-1];
    logic [2*RB-1:0] r_val  [RB-1];

    genvar k;
    generate
        for (k = 0; k < RB; k++) begin : g_stage
            logic [RB+1:0]   p_rem;
            logic [RB-1:0]   p_root;
            logic [2*RB-1:0] p_val;
            logic [TW-1:0]   p_tag;
            logic [RB+1:0]   cur;
            logic [RB+1:0]   trial;
            logic            ge;
            logic [RB+1:0]   n_rem;

            if (k == 0) begin : g_first
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_val  = i_val;
                assign p_tag  = i_tag;
            end else begin : g_next
                assign p_rem  = r_rem[k-1];
                assign p_root = r_root[k-1];
                assign p_val  = r_val[k-1];
                assign p_tag  = r_tag[k-1];
            end

            // bring down the next two bits, try root*4+1
            assign cur   = {p_rem[RB-1:0], p_val[2*RB-1:2*RB-2]};
            assign trial = {p_root, 2'b01};
            assign ge    = (cur >= trial);
            assign n_rem = ge ? (cur - trial) : cur;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_tag[k] <= '0;
                end else if (i_en) begin
                    r_tag[k] <= p_tag;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                end
            end

            if (k < RB-1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_root[k] <= {p_root[RB-2:0], ge};
                        r_val[k]  <= {p_val[2*RB-3:0], 2'b00};
                    end
                end
            end
        end
    endgenerate

    assign o_tag    = r_tag[RB-1];
    assign o_square = (r_rem[RB-1] == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/perfect_triangle_check_core.sv -----
`default_nettype none

// Perfect triangle checker. Takes three unsigned side lengths per request and
// returns four flags: strict triangle inequality, integral medians (for each
// side x with others y,z: 2y^2+2z^2-x^2 positive, divisible by 4, quarter a
// perfect square), integral Heron area (H=(a+b+c)(b+c-a)(a+c-b)(a+b-c)
// positive, divisible by 16, sixteenth a perfect square) and their AND. All
// arithmetic is exact at full width. One request is accepted per cycle unless
// the pipe holds; the latency is set by the bit-per-stage root extraction of
// the (4*SIDE_BITS-2)-bit Heron quotient. Handshake is valid/stall on both
// sides; the pipe only holds when its last stage is live and the output
// register is full and stalled.
module perfect_triangle_check_core #(
    parameter int SIDE_BITS = 31
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [SIDE_BITS-1:0] i_side_a,
    input  wire logic [SIDE_BITS-1:0] i_side_b,
    input  wire logic [SIDE_BITS-1:0] i_side_c,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_is_triangle,
    output logic                      o_medians_integral,
    output logic                      o_area_integral,
    output logic                      o_perfect
);

    import ptc_pkg::*;

    localparam int N   = SIDE_BITS;
    localparam int W2  = 2*N;        // a side squared
    localparam int WX  = 2*N + 2;    // (b+c)^2 and the first Heron factor
    localparam int WP  = 2*N + 1;    // one partial product
    localparam int HW  = 4*N + 2;    // full Heron product
    localparam int RBA = 2*N - 1;    // root bits of H/16
    localparam int MD  = N + 2;      // median flag delay to meet the area pipe

    // pipe advance: only hold when the tail is live and cannot drain
    logic en;
    logic tail_valid;
    assign en      = !(tail_valid && o_valid && i_stall);
    assign o_stall = !en;

    // ---------------- stage 1: squares, triangle test ----------------
    logic [N:0]    s_ab, s_ac, s_bc;
    logic [N-1:0]  s_dbc;
    logic          r1_valid, r1_tri;
    logic [W2-1:0] r1_aa, r1_bb, r1_cc, r1_dsq;
    logic [WX-1:0] r1_bcsq;

    assign s_ab  = {1'b0, i_side_a} + {1'b0, i_side_b};
    assign s_ac  = {1'b0, i_side_a} + {1'b0, i_side_c};
    assign s_bc  = {1'b0, i_side_b} + {1'b0, i_side_c};
    assign s_dbc = (i_side_b > i_side_c) ? (i_side_b - i_side_c) : (i_side_c - i_side_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_tri  <= (s_ab > {1'b0, i_side_c}) && (s_ac > {1'b0, i_side_b})
                    && (s_bc > {1'b0, i_side_a});
            r1_aa   <= W2'(i_side_a) * W2'(i_side_a);
            r1_bb   <= W2'(i_side_b) * W2'(i_side_b);
            r1_cc   <= W2'(i_side_c) * W2'(i_side_c);
            r1_dsq  <= W2'(s_dbc) * W2'(s_dbc);
            r1_bcsq <= WX'(s_bc) * WX'(s_bc);
        end
    end

    // ---------------- stage 2: median residues, Heron factors ----------------
    logic [W2:0]   s_yz  [3];
    logic [W2-1:0] s_xx  [3];
    logic          r2_valid, r2_tri;
    logic [W2-1:0] r2_q    [3];
    logic          r2_mpre [3];
    logic [WX-1:0] r2_x;
    logic [W2-1:0] r2_y;

    assign s_yz[0] = {1'b0, r1_bb} + {1'b0, r1_cc};
    assign s_yz[1] = {1'b0, r1_aa} + {1'b0, r1_cc};
    assign s_yz[2] = {1'b0, r1_aa} + {1'b0, r1_bb};
    assign s_xx[0] = r1_aa;
    assign s_xx[1] = r1_bb;
    assign s_xx[2] = r1_cc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    genvar j;
    generate
        for (j = 0; j < 3; j++) begin : g_med_prep
            logic [WX-1:0] twice;
            logic [WX-1:0] d;
            assign twice = {s_yz[j], 1'b0};
            assign d     = twice - WX'(s_xx[j]);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r2_q[j]    <= d[WX-1:2];
                    r2_mpre[j] <= r1_tri && (twice > WX'(s_xx[j])) && (d[1:0] == 2'b00);
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_tri <= r1_tri;
            r2_x   <= r1_bcsq - WX'(r1_aa);   // (b+c)^2 - a^2
            r2_y   <= r1_aa - r1_dsq;         // a^2 - (b-c)^2
        end
    end

    // ---------------- median roots (start from stage 2) ----------------
    logic m_tag [3];
    logic m_sq  [3];
    logic n_med;

    generate
        for (j = 0; j < 3; j++) begin : g_med_root
            ptc_isqrt #(
                .RB (N),
                .TW (1)
            ) u_med_root (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (en),
                .i_val    (r2_q[j]),
                .i_tag    (r2_mpre[j]),
                .o_tag    (m_tag[j]),
                .o_square (m_sq[j])
            );
        end
    endgenerate

    assign n_med = m_tag[0] && m_sq[0] && m_tag[1] && m_sq[1] && m_tag[2] && m_sq[2];

    // align median verdicts with the longer Heron root pipe
    logic r_mdl [MD];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mdl[0] <= n_med;
            for (int i = 1; i < MD; i++) begin
                r_mdl[i] <= r_mdl[i-1];
            end
        end
    end

    // ---------------- stage 3: partial products ----------------
    logic          r3_valid, r3_tri;
    logic [WP-1:0] r3_p0, r3_p1, r3_p2, r3_p3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
    end

    // x split at N+1 bits, y at N bits
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_tri <= r2_tri;
            r3_p0  <= WP'(r2_x[N:0])        * WP'(r2_y[N-1:0]);
            r3_p1  <= WP'(r2_x[N:0])        * WP'(r2_y[W2-1:N]);
            r3_p2  <= WP'(r2_x[WX-1:N+1])   * WP'(r2_y[N-1:0]);
            r3_p3  <= WP'(r2_x[WX-1:N+1])   * WP'(r2_y[W2-1:N]);
        end
    end

    // ---------------- stage 4: pairwise sums ----------------
    logic          r4_valid, r4_tri;
    logic [HW-1:0] r4_t1, r4_t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_tri <= r3_tri;
            r4_t1  <= HW'(r3_p0) + (HW'(r3_p1) << N);
            r4_t2  <= (HW'(r3_p2) << (N+1)) + (HW'(r3_p3) << (2*N+1));
        end
    end

    // ---------------- stage 5: Heron product, divisibility ----------------
    logic [HW-1:0]   s_h;
    t_area_tag       r5_tag;
    logic [HW-5:0]   r5_q;

    assign s_h = r4_t1 + r4_t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_tag.valid <= 1'b0;
        end else if (en) begin
            r5_tag.valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_tag.tri_ok <= r4_tri;
            r5_tag.pre    <= r4_tri && (s_h != '0) && (s_h[3:0] == 4'h0);
            r5_q          <= s_h[HW-1:4];
        end
    end

    // valid rides in the tag from here on
    t_area_tag a_tag;
    logic      a_sq;

    ptc_isqrt #(
        .RB (RBA),
        .TW (AREA_TAG_W)
    ) u_area_root (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_val    (r5_q),
        .i_tag    (r5_tag),
        .o_tag    (a_tag),
        .o_square (a_sq)
    );

    assign tail_valid = a_tag.valid;

    // ---------------- output register ----------------
    logic r_out_valid, r_tri, r_med, r_area;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!(r_out_valid && i_stall)) begin
            r_out_valid <= tail_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!(r_out_valid && i_stall)) begin
            r_tri  <= a_tag.tri_ok;
            r_med  <= r_mdl[MD-1];
            r_area <= a_tag.pre && a_sq;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_is_triangle      = r_tri;
    assign o_medians_integral = r_med;
    assign o_area_integral    = r_area;
    assign o_perfect          = r_tri && r_med && r_area;

    // ---------------- assertions ----------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output register free");

    a_med_needs_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_medians_integral) |-> o_is_triangle)
        else $error("median flag out of step with triangle flag");

    a_area_needs_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_area_integral) |-> o_is_triangle)
        else $error("area flag out of step with triangle flag");

endmodule

`default_nettype wire

// ----- sim/perfect_triangle_check_core_tb.sv -----
module perfect_triangle_check_core_tb;

    localparam int SIDE_BITS  = 31;
    localparam int WDOG_LIMIT = 20000;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        logic [SIDE_BITS-1:0] a;
        logic [SIDE_BITS-1:0] b;
        logic [SIDE_BITS-1:0] c;
    } t_sides;

    typedef struct {
        logic tri_ok;
        logic med_ok;
        logic area_ok;
        logic perf;
    } t_flags;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [SIDE_BITS-1:0] i_side_a;
    logic [SIDE_BITS-1:0] i_side_b;
    logic [SIDE_BITS-1:0] i_side_c;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_is_triangle;
    logic                 o_medians_integral;
    logic                 o_area_integral;
    logic                 o_perfect;

    t_sides pending_sides[$];
    t_flags flags_due[$];

    int n_errors      = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req      = 0;
    int hold_ack      = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    perfect_triangle_check_core #(
        .SIDE_BITS(SIDE_BITS)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_side_a          (i_side_a),
        .i_side_b          (i_side_b),
        .i_side_c          (i_side_c),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_is_triangle     (o_is_triangle),
        .o_medians_integral(o_medians_integral),
        .o_area_integral   (o_area_integral),
        .o_perfect         (o_perfect)
    );

    // Clock: period 2.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Exact perfect-square test by bit-serial root extraction.
    function automatic logic perfect_sq(logic [127:0] n);
        logic [63:0]  root;
        logic [63:0]  cand;
        logic [127:0] sq;
        root = '0;
        for (int bit_i = 63; bit_i >= 0; bit_i--) begin
            cand = root | (64'd1 << bit_i);
            sq   = {64'd0, cand} * {64'd0, cand};
            if (sq <= n) root = cand;
        end
        sq = {64'd0, root} * {64'd0, root};
        return sq == n;
    endfunction

    // Median of side x is integral when (2y^2+2z^2-x^2)/4 is a square.
    function automatic logic median_ok(logic [SIDE_BITS-1:0] x, logic [SIDE_BITS-1:0] y,
                                       logic [SIDE_BITS-1:0] z);
        logic [127:0] twice;
        logic [127:0] xx;
        logic [127:0] d;
        twice = ({97'd0, y} * {97'd0, y} + {97'd0, z} * {97'd0, z}) << 1;
        xx    = {97'd0, x} * {97'd0, x};
        if (twice <= xx) return 1'b0;
        d = twice - xx;
        if (d[1:0] != 2'b00) return 1'b0;
        return perfect_sq(d >> 2);
    endfunction

    function automatic t_flags triangle_flags(t_sides s);
        t_flags       f;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] c;
        logic [127:0] bc;
        logic [127:0] dbc;
        logic [127:0] heron;
        a = {97'd0, s.a};
        b = {97'd0, s.b};
        c = {97'd0, s.c};
        f.tri_ok  = (a + b > c) && (a + c > b) && (b + c > a);
        f.med_ok  = 1'b0;
        f.area_ok = 1'b0;
        if (f.tri_ok) begin
            f.med_ok = median_ok(s.a, s.b, s.c) && median_ok(s.b, s.a, s.c)
                     && median_ok(s.c, s.a, s.b);
            // H = ((b+c)^2 - a^2) * (a^2 - (b-c)^2), both factors positive
            bc    = b + c;
            dbc   = (b > c) ? (b - c) : (c - b);
            heron = (bc * bc - a * a) * (a * a - dbc * dbc);
            if (heron != 0 && heron[3:0] == 4'd0)
                f.area_ok = perfect_sq(heron >> 4);
        end
        f.perf = f.tri_ok && f.med_ok && f.area_ok;
        return f;
    endfunction

    task automatic report_mismatch(string what, logic got, logic want);
        $display("mismatch %s: got %0b want %0b", what, got, want);
        n_errors++;
    endtask

    task automatic add_req(logic [SIDE_BITS-1:0] a, logic [SIDE_BITS-1:0] b,
                           logic [SIDE_BITS-1:0] c);
        t_sides s;
        s.a = a;
        s.b = b;
        s.c = c;
        pending_sides.push_back(s);
    endtask

    // Random request: mostly scaled known-good shapes and small sides, rest full range, some near-degenerate.
    task automatic add_random_req();
        int unsigned k;
        int unsigned sel;
        logic [SIDE_BITS-1:0] a, b, c;
        sel = $urandom_range(0, 9);
        k   = $urandom_range(1, 2000000);
        case (sel)
            0: begin
                a = SIDE_BITS'(3 * k); b = SIDE_BITS'(4 * k); c = SIDE_BITS'(5 * k);
            end
            1: begin
                a = SIDE_BITS'(5 * k); b = SIDE_BITS'(5 * k); c = SIDE_BITS'(6 * k);
            end
            2: begin
                k = $urandom_range(1, 12000000);
                a = SIDE_BITS'(136 * k); b = SIDE_BITS'(170 * k); c = SIDE_BITS'(174 * k);
            end
            3: begin
                a = SIDE_BITS'(13 * k); b = SIDE_BITS'(14 * k); c = SIDE_BITS'(15 * k);
            end
            4, 5: begin
                a = SIDE_BITS'($urandom_range(1, 60));
                b = SIDE_BITS'($urandom_range(1, 60));
                c = SIDE_BITS'($urandom_range(1, 60));
            end
            6: begin
                a = SIDE_BITS'($urandom);
                b = SIDE_BITS'($urandom);
                c = SIDE_BITS'(a + b - $urandom_range(0, 3));
            end
            default: begin
                a = SIDE_BITS'($urandom);
                b = SIDE_BITS'($urandom);
                c = SIDE_BITS'($urandom);
            end
        endcase
        // rotate side order
        case ($urandom_range(0, 2))
            0: add_req(a, b, c);
            1: add_req(b, c, a);
            default: add_req(c, a, b);
        endcase
    endtask

    // Driver: holds a stalled request, else offers the next or idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                flags_due.push_back(triangle_flags('{i_side_a, i_side_b, i_side_c}));
            if (!(i_valid && o_stall)) begin
                if (pending_sides.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid  <= 1'b1;
                    i_side_a <= pending_sides[0].a;
                    i_side_b <= pending_sides[0].b;
                    i_side_c <= pending_sides[0].c;
                    void'(pending_sides.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks results against the oldest expected flags, drives stall.
    always @(posedge i_clk) begin
        t_flags want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (flags_due.size() == 0) begin
                report_mismatch("unexpected result", 1'b1, 1'b0);
            end else begin
                want = flags_due.pop_front();
                if (o_is_triangle !== want.tri_ok)
                    report_mismatch("is_triangle", o_is_triangle, want.tri_ok);
                if (o_medians_integral !== want.med_ok)
                    report_mismatch("medians_integral", o_medians_integral, want.med_ok);
                if (o_area_integral !== want.area_ok)
                    report_mismatch("area_integral", o_area_integral, want.area_ok);
                if (o_perfect !== want.perf)
                    report_mismatch("perfect", o_perfect, want.perf);
            end
        end
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_LEN;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog: cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("perfect_triangle_check_core_tb failed");
            $finish;
        end
    end

    // sampled on the falling edge, after the driver and monitor have settled
    task automatic wait_sent();
        while (pending_sides.size() > 0 || i_valid) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        wait_sent();
        while (flags_due.size() > 0) @(negedge i_clk);
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) add_random_req();
        wait_sent();
    endtask

    localparam logic [SIDE_BITS-1:0] MAXS = '1;

    initial begin
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_stall  = 1'b0;
        i_side_a = '0;
        i_side_b = '0;
        i_side_c = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero sides, extremes, degenerate, known shapes.
        add_req(0, 0, 0);
        add_req(0, 5, 5);
        add_req(MAXS, MAXS, MAXS);
        add_req(MAXS, MAXS, 1);
        add_req(MAXS, SIDE_BITS'(MAXS - 1), 1);
        add_req(1, MAXS, MAXS);
        add_req(1, 1, 1);
        add_req(1, 1, 2);
        add_req(2, 3, 5);
        add_req(3, 4, 5);
        add_req(5, 5, 6);
        add_req(13, 14, 15);
        add_req(136, 170, 174);
        add_req(174, 136, 170);
        add_req(68, 85, 87);
        add_req(1, 2, 10);
        add_req(MAXS, 0, MAXS);
        add_req(31'h40000000, 31'h40000000, 31'h7FFFFFFF);
        add_req(31'h55555555, 31'h2AAAAAAA, 31'h55555555);
        add_req(SIDE_BITS'(MAXS / 5 * 3), SIDE_BITS'(MAXS / 5 * 4),
                SIDE_BITS'(MAXS / 5 * 5));
        wait_drained();

        run_phase(325, 0, 0);
        // long receiver hold while requests keep coming, so the pipe backs up
        hold_req = hold_req + 1;
        run_phase(325, 79, 0);
        wait_drained();
        run_phase(325, 0, 79);
        hold_req = hold_req + 1;
        run_phase(325, 13, 13);

        wait_drained();
        repeat (80) @(posedge i_clk);
        if (n_errors == 0 && flags_due.size() == 0)
            $display("perfect_triangle_check_core_tb passed");
        else
            $display("perfect_triangle_check_core_tb failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_isqrt.sv
hw/rtl/perfect_triangle_check_core.sv
sim/perfect_triangle_check_core_tb.sv
